[src/tspat_pkg.sv]
package tspat_pkg;

  localparam logic [11:0] POS_MAX     = 12'd4095;
  localparam logic [11:0] HEADER_LAST = 12'd7;
  localparam logic [11:0] LOOP_FIRST  = 12'd8;
  localparam logic [12:0] CRC_BYTES   = 13'd4;

  typedef enum logic [1:0] {
    KIND_PROGRAM = 2'd0,
    KIND_NETWORK = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  tbl_id;
    logic        syntax_indicator;
    logic [11:0] sec_len;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  sec_num;
    logic [7:0]  last_sec_num;
  } hdr_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] program_number;
    logic [12:0] pid;
    hdr_t        hdr;
    logic [31:0] crc_value;
  } res_t;

endpackage

[src/tspat_parse.sv]
module tspat_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               section_start,
  output logic               res_valid,
  output tspat_pkg::res_t    res
);

  logic               in_section;
  logic               in_section_next;
  logic [11:0]        byte_position;
  logic [11:0]        byte_position_next;
  tspat_pkg::hdr_t    hdr;
  tspat_pkg::hdr_t    hdr_next;
  tspat_pkg::hdr_t    hdr_base;
  logic [23:0]        entry_shift;
  logic [23:0]        entry_shift_next;
  logic [23:0]        entry_base;
  logic [31:0]        crc_shift;
  logic [31:0]        crc_shift_next;
  logic [31:0]        crc_base;
  logic [12:0]        end_sum;
  logic [11:0]        end_pos;
  logic               active;

  assign active = take && (section_start || in_section);

  always_comb begin
    in_section_next    = in_section;
    byte_position_next = byte_position;
    hdr_next           = hdr;
    entry_shift_next   = entry_shift;
    crc_shift_next     = crc_shift;
    hdr_base           = hdr;
    entry_base         = entry_shift;
    crc_base           = crc_shift;
    end_sum            = '0;
    end_pos            = '0;
    res_valid          = 1'b0;
    res                = '0;
    if (active) begin
      if (section_start) begin
        // a start always reopens, abandoning any open section
        hdr_base           = '0;
        entry_base         = '0;
        crc_base           = '0;
        byte_position_next = '0;
        in_section_next    = 1'b1;
      end else if (byte_position != tspat_pkg::POS_MAX) begin
        byte_position_next = byte_position + 12'd1;
      end
      crc_shift_next   = {crc_base[23:0], data_byte};
      hdr_next         = hdr_base;
      entry_shift_next = entry_base;
      unique case (byte_position_next)
        12'd0: hdr_next.tbl_id = data_byte;
        12'd1: begin
          hdr_next.syntax_indicator = data_byte[7];
          hdr_next.sec_len[11:8]    = data_byte[3:0];
        end
        12'd2: hdr_next.sec_len[7:0] = data_byte;
        12'd3: hdr_next.stream_id[15:8] = data_byte;
        12'd4: hdr_next.stream_id[7:0] = data_byte;
        12'd5: begin
          hdr_next.version      = data_byte[5:1];
          hdr_next.current_next = data_byte[0];
        end
        12'd6: hdr_next.sec_num = data_byte;
        12'd7: hdr_next.last_sec_num = data_byte;
        default: ;
      endcase

      // last byte index, clamped to the header and to the counter range
      end_sum = {1'b0, hdr_next.sec_len} + 13'd2;
      if (end_sum < {1'b0, tspat_pkg::HEADER_LAST}) begin
        end_pos = tspat_pkg::HEADER_LAST;
      end else if (end_sum > {1'b0, tspat_pkg::POS_MAX}) begin
        end_pos = tspat_pkg::POS_MAX;
      end else begin
        end_pos = end_sum[11:0];
      end

      res.hdr = hdr_next;
      if (byte_position_next >= tspat_pkg::LOOP_FIRST &&
          ({1'b0, byte_position_next} + tspat_pkg::CRC_BYTES) <= {1'b0, end_pos}) begin
        if (byte_position_next[1:0] == 2'd3) begin
          res_valid          = 1'b1;
          res.pid            = {entry_base[4:0], data_byte};
          if (entry_base[23:8] == 16'd0) begin
            res.kind = tspat_pkg::KIND_NETWORK;
          end else begin
            res.kind           = tspat_pkg::KIND_PROGRAM;
            res.program_number = entry_base[23:8];
          end
          entry_shift_next = '0;
        end else begin
          entry_shift_next = {entry_base[15:0], data_byte};
        end
      end

      if (byte_position_next >= end_pos) begin
        res_valid          = 1'b1;
        res.kind           = tspat_pkg::KIND_SUMMARY;
        res.program_number = '0;
        res.pid            = '0;
        res.crc_value      = crc_shift_next;
        in_section_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_section    <= 1'b0;
      byte_position <= '0;
      hdr           <= '0;
      entry_shift   <= '0;
      crc_shift     <= '0;
    end else begin
      in_section    <= in_section_next;
      byte_position <= byte_position_next;
      hdr           <= hdr_next;
      entry_shift   <= entry_shift_next;
      crc_shift     <= crc_shift_next;
    end
  end

  a_summary_closes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == tspat_pkg::KIND_SUMMARY) |=> !in_section)
    else $error("section still open after summary");

  a_idle_bytes_ignored: assert property (@(posedge clk) disable iff (rst)
    (take && !section_start && !in_section) |=> ($stable(byte_position) && $stable(crc_shift)))
    else $error("byte outside a section changed state");

  a_result_needs_section: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (take && (section_start || in_section)))
    else $error("result without an active byte");

endmodule

[src/tspat_outbuf.sv]
module tspat_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tspat_pkg::res_t    push_res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tspat_pkg::res_t    out_res
);

  logic              skid_valid;
  tspat_pkg::res_t   skid_res;
  logic              pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_res <= push_res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_res   <= push_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= push_res;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without main entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("request lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (!skid_valid && out_valid))
    else $error("skid entry not moved forward");

endmodule

[src/ts_pat_section_parser.sv]
// Throughput: one byte per cycle while in_ready is high; each byte is parsed in a single pass
// from the state registers; results are registered in the output buffer that drives the outputs.
// A two-entry output buffer lets the input keep taking bytes while a result waits;
// in_ready drops only when both entries are full.
// Reset (synchronous, active high) closes any open section and clears header, entry and CRC state.
module ts_pat_section_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] program_number,
  output logic [12:0] pid,
  output logic [7:0]  tbl_id,
  output logic        syntax_indicator,
  output logic [11:0] sec_len,
  output logic [15:0] stream_id,
  output logic [4:0]  version,
  output logic        current_next,
  output logic [7:0]  sec_num,
  output logic [7:0]  last_sec_num,
  output logic [31:0] crc_value
);

  logic              take;
  logic              res_valid;
  tspat_pkg::res_t   res;
  tspat_pkg::res_t   out_res;

  assign take = in_valid && in_ready;

  tspat_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .section_start (section_start),
    .res_valid     (res_valid),
    .res           (res)
  );

  tspat_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind             = out_res.kind;
  assign program_number   = out_res.program_number;
  assign pid              = out_res.pid;
  assign tbl_id           = out_res.hdr.tbl_id;
  assign syntax_indicator = out_res.hdr.syntax_indicator;
  assign sec_len          = out_res.hdr.sec_len;
  assign stream_id        = out_res.hdr.stream_id;
  assign version          = out_res.hdr.version;
  assign current_next     = out_res.hdr.current_next;
  assign sec_num          = out_res.hdr.sec_num;
  assign last_sec_num     = out_res.hdr.last_sec_num;
  assign crc_value        = out_res.crc_value;

endmodule

[bench/ts_pat_section_parser_tb.sv]
`timescale 1ns / 1ps

module ts_pat_section_parser_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] data;
    logic       start;
    int         phase;
    bit         drain;
    bit         hold;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] program_number;
  logic [12:0] pid;
  logic [7:0]  tbl_id;
  logic        syntax_indicator;
  logic [11:0] sec_len;
  logic [15:0] stream_id;
  logic [4:0]  version;
  logic        current_next;
  logic [7:0]  sec_num;
  logic [7:0]  last_sec_num;
  logic [31:0] crc_value;

  ts_pat_section_parser u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .section_start    (section_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .program_number   (program_number),
    .pid              (pid),
    .tbl_id           (tbl_id),
    .syntax_indicator (syntax_indicator),
    .sec_len          (sec_len),
    .stream_id        (stream_id),
    .version          (version),
    .current_next     (current_next),
    .sec_num          (sec_num),
    .last_sec_num     (last_sec_num),
    .crc_value        (crc_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  byte_req_t         section_bytes[$];
  tspat_pkg::res_t   pat_results_due[$];
  int                mismatches = 0;
  int                cycles = 0;
  int                send_idle = 34;
  int                recv_idle = 62;
  int unsigned       hold_asked = 0;
  int unsigned       hold_served = 0;
  int                hold_left = 0;

  // predictor state
  logic              sec_open = 1'b0;
  logic [11:0]       sec_pos = '0;
  tspat_pkg::hdr_t   sec_hdr = '0;
  logic [23:0]       entry_acc = '0;
  logic [31:0]       tail_bytes = '0;

  // stimulus generation state
  int gen_phase = 0;
  int gen_count = 0;
  bit gen_drain = 1'b0;
  bit gen_hold = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Work out the PAT result (if any) for one accepted request.
  task automatic parse_byte(input logic [7:0] b, input logic s);
    logic [12:0]     stop;
    logic [12:0]     pos_ext;
    logic            live;
    tspat_pkg::res_t r;
    live = 1'b1;
    if (s) begin
      sec_hdr    = '0;
      sec_pos    = '0;
      entry_acc  = '0;
      tail_bytes = '0;
      sec_open   = 1'b1;
    end else if (!sec_open) begin
      live = 1'b0;
    end else if (sec_pos != tspat_pkg::POS_MAX) begin
      sec_pos = sec_pos + 12'd1;
    end
    if (live) begin
      tail_bytes = {tail_bytes[23:0], b};
      case (sec_pos)
        12'd0: sec_hdr.tbl_id = b;
        12'd1: begin
          sec_hdr.syntax_indicator = b[7];
          sec_hdr.sec_len[11:8] = b[3:0];
        end
        12'd2: sec_hdr.sec_len[7:0] = b;
        12'd3: sec_hdr.stream_id[15:8] = b;
        12'd4: sec_hdr.stream_id[7:0] = b;
        12'd5: begin
          sec_hdr.version = b[5:1];
          sec_hdr.current_next = b[0];
        end
        12'd6: sec_hdr.sec_num = b;
        12'd7: sec_hdr.last_sec_num = b;
        default: ;
      endcase
      stop = {1'b0, sec_hdr.sec_len} + 13'd2;
      if (stop < {1'b0, tspat_pkg::HEADER_LAST}) stop = {1'b0, tspat_pkg::HEADER_LAST};
      if (stop > {1'b0, tspat_pkg::POS_MAX}) stop = {1'b0, tspat_pkg::POS_MAX};
      pos_ext = {1'b0, sec_pos};
      // loop bytes stop short of the four CRC bytes
      if (sec_pos >= tspat_pkg::LOOP_FIRST && pos_ext + tspat_pkg::CRC_BYTES <= stop) begin
        if (sec_pos[1:0] == 2'b11) begin
          r = '0;
          r.hdr = sec_hdr;
          r.pid = {entry_acc[4:0], b};
          if (entry_acc[23:8] == 16'h0000) begin
            r.kind = tspat_pkg::KIND_NETWORK;
          end else begin
            r.kind = tspat_pkg::KIND_PROGRAM;
            r.program_number = entry_acc[23:8];
          end
          pat_results_due.push_back(r);
          entry_acc = '0;
        end else begin
          entry_acc = {entry_acc[15:0], b};
        end
      end
      if (pos_ext >= stop) begin
        r = '0;
        r.kind = tspat_pkg::KIND_SUMMARY;
        r.hdr = sec_hdr;
        r.crc_value = tail_bytes;
        pat_results_due.push_back(r);
        sec_open = 1'b0;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s, input bit counted);
    byte_req_t q;
    q.data  = b;
    q.start = s;
    q.phase = gen_phase;
    q.drain = gen_drain;
    q.hold  = gen_hold;
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
    section_bytes.push_back(q);
    if (counted) gen_count++;
  endtask

  // One section with random content; cut > 0 abandons it after that many bytes.
  task automatic gen_section(input logic [11:0] len, input int cut);
    int         last;
    int         n;
    int         prog_mode;
    logic [7:0] b;
    last = len + 2;
    if (last < 7) last = 7;
    if (last > 4095) last = 4095;
    n = last + 1;
    if (cut > 0 && cut < n) n = cut;
    prog_mode = 0;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i == 1) begin
        b[3:0] = len[11:8];
      end else if (i == 2) begin
        b = len[7:0];
      end else if (i >= 8 && i + 4 <= last) begin
        if ((i - 8) % 4 == 0) prog_mode = $urandom_range(0, 9);
        // program number 0 marks a network entry
        if ((i - 8) % 4 < 2) begin
          if (prog_mode < 2) b = 8'h00;
          else if (prog_mode == 2) b = 8'hFF;
        end
      end
      push_byte(b, i == 0, 1'b1);
    end
  endtask

  task automatic rand_section();
    int pick;
    int len;
    int cut;
    pick = $urandom_range(0, 99);
    cut = 0;
    if (pick < 10) begin
      for (int i = $urandom_range(1, 4); i > 0; i--) push_byte(8'($urandom), 1'b0, 1'b0);
    end
    if (pick < 20) len = $urandom_range(0, 8);
    else if (pick >= 95) len = $urandom_range(0, 300);
    else len = 9 + 4 * $urandom_range(0, 8) + ((pick < 30) ? $urandom_range(1, 3) : 0);
    if (pick >= 30 && pick < 40) cut = $urandom_range(1, len + 2);
    gen_section(len[11:0], cut);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(data_byte, section_start);
      if (!in_valid || in_ready) begin
        if (section_bytes.size() != 0 &&
            !(section_bytes[0].drain && pat_results_due.size() != 0) &&
            $urandom_range(0, 99) >= send_idle) begin
          in_valid      <= 1'b1;
          data_byte     <= section_bytes[0].data;
          section_start <= section_bytes[0].start;
          case (section_bytes[0].phase)
            0: begin
              send_idle <= 34;
              recv_idle <= 62;
            end
            1: begin
              send_idle <= 62;
              recv_idle <= 34;
            end
            default: begin
              send_idle <= 0;
              recv_idle <= 0;
            end
          endcase
          if (section_bytes[0].hold) hold_asked <= hold_asked + 1;
          void'(section_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  tspat_pkg::res_t want;

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pat_results_due.size() == 0) begin
          report_mismatch("result with nothing pending", {30'd0, kind}, 32'd0);
        end else begin
          want = pat_results_due.pop_front();
          check_field("kind", 32'(kind), 32'(want.kind));
          check_field("program_number", 32'(program_number), 32'(want.program_number));
          check_field("pid", 32'(pid), 32'(want.pid));
          check_field("tbl_id", 32'(tbl_id), 32'(want.hdr.tbl_id));
          check_field("syntax_indicator", 32'(syntax_indicator),
                      32'(want.hdr.syntax_indicator));
          check_field("sec_len", 32'(sec_len), 32'(want.hdr.sec_len));
          check_field("stream_id", 32'(stream_id), 32'(want.hdr.stream_id));
          check_field("version", 32'(version), 32'(want.hdr.version));
          check_field("current_next", 32'(current_next), 32'(want.hdr.current_next));
          check_field("sec_num", 32'(sec_num), 32'(want.hdr.sec_num));
          check_field("last_sec_num", 32'(last_sec_num), 32'(want.hdr.last_sec_num));
          check_field("crc_value", crc_value, want.crc_value);
        end
      end
      out_ready <= (hold_left == 0) && (hold_asked == hold_served) &&
                   ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // ignored bytes outside any section
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // a section abandoned by a new start
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    // short section, length 0, all other header bits set
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'hF0, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) push_byte(8'hFF, 1'b0, 1'b1);
    // one network entry with the largest PID, header zero apart from the length
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h0D, 1'b0, 1'b1);
    for (int i = 0; i < 7; i++) push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) push_byte(8'h00, 1'b0, 1'b1);

    while (gen_count < 500) rand_section();
    gen_phase = 1;
    gen_drain = 1'b1;
    while (gen_count < 1000) rand_section();
    gen_phase = 2;
    gen_drain = 1'b1;
    gen_hold  = 1'b1;
    gen_section(12'd129, 0);
    while (gen_count < 1500) rand_section();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (section_bytes.size() != 0 || in_valid || pat_results_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
